>>> src/ifke_pkg.sv
// ----------------------------------------------------------------------------
// ifke_pkg
// Shared types and constants for the IPv4 flow key extractor.
// ----------------------------------------------------------------------------
package ifke_pkg;

  // Frame layout
  localparam int unsigned OFF_W        = 7;
  localparam logic [6:0]  OFF_MAX      = 7'd127;
  localparam logic [6:0]  OFF_IHL      = 7'd14;   // version/IHL byte
  localparam logic [6:0]  OFF_PROTO    = 7'd23;
  localparam logic [6:0]  OFF_SRC_FIRST = 7'd26;
  localparam logic [6:0]  OFF_SRC_LAST  = 7'd29;
  localparam logic [6:0]  OFF_DST_FIRST = 7'd30;
  localparam logic [6:0]  OFF_DST_LAST  = 7'd33;
  localparam logic [6:0]  ETH_HDR_LEN  = 7'd14;

  // IP protocol numbers
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Traffic classes
  localparam logic [2:0]  CLS_TCP   = 3'd0;
  localparam logic [2:0]  CLS_HTTP  = 3'd1;
  localparam logic [2:0]  CLS_HTTPS = 3'd2;
  localparam logic [2:0]  CLS_DNS   = 3'd3;
  localparam logic [2:0]  CLS_UDP   = 3'd4;
  localparam logic [2:0]  CLS_OTHER = 3'd5;

  // Configuration register map
  localparam int unsigned CFG_IDX_W      = 8;
  localparam logic [7:0]  REG_HTTP_MAIN  = 8'd0;
  localparam logic [7:0]  REG_HTTP_ALT   = 8'd1;
  localparam logic [7:0]  REG_HTTPS      = 8'd2;
  localparam logic [7:0]  REG_DNS        = 8'd3;

  localparam logic [15:0] RST_HTTP_MAIN  = 16'd80;
  localparam logic [15:0] RST_HTTP_ALT   = 16'd8080;
  localparam logic [15:0] RST_HTTPS      = 16'd443;
  localparam logic [15:0] RST_DNS        = 16'd53;

endpackage

>>> src/ipv4_flow_key_extractor.sv
// ----------------------------------------------------------------------------
// ipv4_flow_key_extractor
// Parses an Ethernet/IPv4 frame byte stream into a five-tuple flow key.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per request (in_frame_byte, in_frame_end marks the
//           last byte). A request is taken when in_valid is high and in_stall
//           is low.
//   out_* : one flow key per frame, presented on the request that carries the
//           frame's last byte. Taken when out_valid is high and out_stall low.
//   cfg_* : register writes (index, 16-bit data); cfg_ready is always high.
//           Write only while no frame is in flight.
// Timing: a byte is registered at the input and processed from the input
//   register; the flow key of a last byte is registered in the result register.
// Throughput: one byte per clock while in_stall is low; the per-byte work is a
//   handful of offset compares and byte shifts between the input register and
//   the state/result registers.
// Stall: non-last bytes never wait on the output. A last byte waits in the
//   input register while a previous key is still held; in_stall then rises.
// Reset: rst_n (sync, active low) clears frame state, empties both stages and
//   restores the port registers to 80, 8080, 443 and 53.
// Bytes past offset 127 capture nothing.
// ----------------------------------------------------------------------------
module ipv4_flow_key_extractor (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [7:0]  out_ip_protocol,
  output logic [2:0]  out_traffic_class,
  output logic        out_truncated,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ifke_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // ---------------- configuration registers ----------------
  logic [15:0] http_main_r, http_alt_r, https_r, dns_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      http_main_r <= ifke_pkg::RST_HTTP_MAIN;
      http_alt_r  <= ifke_pkg::RST_HTTP_ALT;
      https_r     <= ifke_pkg::RST_HTTPS;
      dns_r       <= ifke_pkg::RST_DNS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ifke_pkg::REG_HTTP_MAIN: http_main_r <= cfg_data;
        ifke_pkg::REG_HTTP_ALT:  http_alt_r  <= cfg_data;
        ifke_pkg::REG_HTTPS:     https_r     <= cfg_data;
        ifke_pkg::REG_DNS:       dns_r       <= cfg_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_end_r;
  logic       a_fire;
  logic       out_free;
  logic       in_accept;

  // A slot opens in the output register if it is empty or drains this cycle.
  assign out_free  = !out_valid || !out_stall;
  // Only a last byte needs the output register.
  assign a_fire    = a_valid_r && (!a_end_r || out_free);
  assign in_stall  = a_valid_r && !a_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_accept) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_byte_r <= in_frame_byte;
      a_end_r  <= in_frame_end;
    end
  end

  // ---------------- frame state ----------------
  logic [ifke_pkg::OFF_W-1:0] off_r;
  logic [3:0]  hdr_words_r;
  logic [7:0]  proto_r;
  logic [31:0] src_addr_r, dst_addr_r;
  logic [15:0] src_port_r, dst_port_r;

  logic [3:0]  hdr_words_nxt;
  logic [7:0]  proto_nxt;
  logic [31:0] src_addr_nxt, dst_addr_nxt;
  logic [15:0] src_port_nxt, dst_port_nxt;
  logic [ifke_pkg::OFF_W-1:0] port_off;   // 14 + 4*IHL, at most 74
  logic [ifke_pkg::OFF_W-1:0] need_off;
  logic        is_tcp, is_udp, is_l4;
  logic [2:0]  cls;

  always_comb begin
    hdr_words_nxt = (off_r == ifke_pkg::OFF_IHL) ? a_byte_r[3:0] : hdr_words_r;
    proto_nxt     = (off_r == ifke_pkg::OFF_PROTO) ? a_byte_r : proto_r;

    src_addr_nxt = src_addr_r;
    if (off_r >= ifke_pkg::OFF_SRC_FIRST && off_r <= ifke_pkg::OFF_SRC_LAST) begin
      src_addr_nxt = {src_addr_r[23:0], a_byte_r};
    end
    dst_addr_nxt = dst_addr_r;
    if (off_r >= ifke_pkg::OFF_DST_FIRST && off_r <= ifke_pkg::OFF_DST_LAST) begin
      dst_addr_nxt = {dst_addr_r[23:0], a_byte_r};
    end

    // IHL from this very byte counts (header length zero puts ports at 14).
    port_off = ifke_pkg::ETH_HDR_LEN + {1'b0, hdr_words_nxt, 2'b00};

    src_port_nxt = src_port_r;
    if (off_r == port_off || off_r == port_off + 7'd1) begin
      src_port_nxt = {src_port_r[7:0], a_byte_r};
    end
    dst_port_nxt = dst_port_r;
    if (off_r == port_off + 7'd2 || off_r == port_off + 7'd3) begin
      dst_port_nxt = {dst_port_r[7:0], a_byte_r};
    end

    is_tcp   = (proto_nxt == ifke_pkg::PROTO_TCP);
    is_udp   = (proto_nxt == ifke_pkg::PROTO_UDP);
    is_l4    = is_tcp || is_udp;
    need_off = is_l4 ? port_off + 7'd3 : ifke_pkg::OFF_DST_LAST;

    // HTTP wins over HTTPS, HTTPS over DNS when registers overlap.
    if (is_tcp) begin
      if (dst_port_nxt == http_main_r || dst_port_nxt == http_alt_r) begin
        cls = ifke_pkg::CLS_HTTP;
      end else if (dst_port_nxt == https_r) begin
        cls = ifke_pkg::CLS_HTTPS;
      end else if (dst_port_nxt == dns_r) begin
        cls = ifke_pkg::CLS_DNS;
      end else begin
        cls = ifke_pkg::CLS_TCP;
      end
    end else if (is_udp) begin
      cls = ifke_pkg::CLS_UDP;
    end else begin
      cls = ifke_pkg::CLS_OTHER;
    end
  end

  // Per-frame state clears on the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      hdr_words_r <= '0;
      proto_r     <= '0;
      src_addr_r  <= '0;
      dst_addr_r  <= '0;
      src_port_r  <= '0;
      dst_port_r  <= '0;
    end else if (a_fire) begin
      if (a_end_r) begin
        off_r       <= '0;
        hdr_words_r <= '0;
        proto_r     <= '0;
        src_addr_r  <= '0;
        dst_addr_r  <= '0;
        src_port_r  <= '0;
        dst_port_r  <= '0;
      end else begin
        if (off_r != ifke_pkg::OFF_MAX) begin
          off_r <= off_r + 7'd1;
        end
        hdr_words_r <= hdr_words_nxt;
        proto_r     <= proto_nxt;
        src_addr_r  <= src_addr_nxt;
        dst_addr_r  <= dst_addr_nxt;
        src_port_r  <= src_port_nxt;
        dst_port_r  <= dst_port_nxt;
      end
    end
  end

  // ---------------- result register ----------------
  logic        out_valid_r;
  logic [31:0] o_src_addr_r, o_dst_addr_r;
  logic [15:0] o_src_port_r, o_dst_port_r;
  logic [7:0]  o_proto_r;
  logic [2:0]  o_cls_r;
  logic        o_trunc_r;
  logic        key_load;

  assign key_load = a_fire && a_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (key_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_load) begin
      o_src_addr_r <= src_addr_nxt;
      o_dst_addr_r <= dst_addr_nxt;
      o_src_port_r <= is_l4 ? src_port_nxt : 16'd0;
      o_dst_port_r <= is_l4 ? dst_port_nxt : 16'd0;
      o_proto_r    <= proto_nxt;
      o_cls_r      <= cls;
      o_trunc_r    <= (off_r < need_off);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_source_address = o_src_addr_r;
  assign out_dest_address   = o_dst_addr_r;
  assign out_src_port       = o_src_port_r;
  assign out_dst_port       = o_dst_port_r;
  assign out_ip_protocol    = o_proto_r;
  assign out_traffic_class  = o_cls_r;
  assign out_truncated      = o_trunc_r;

endmodule

>>> src/ifke_checker.sv
// ----------------------------------------------------------------------------
// ifke_checker
// Port-level checks for the IPv4 flow key extractor, bound to the top level.
// ----------------------------------------------------------------------------
module ifke_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_source_address,
  input logic [31:0] out_dest_address,
  input logic [15:0] out_src_port,
  input logic [15:0] out_dst_port,
  input logic [7:0]  out_ip_protocol,
  input logic [2:0]  out_traffic_class
);

  // Held key's addresses, destination port and class stay put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_source_address) &&
      $stable(out_dest_address) && $stable(out_dst_port) &&
      $stable(out_traffic_class))
    else $error("flow key changed while stalled");

  // Non-transport protocols carry zero ports and class OTHER.
  a_other: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ip_protocol != ifke_pkg::PROTO_TCP &&
      out_ip_protocol != ifke_pkg::PROTO_UDP |->
      out_src_port == 16'd0 && out_dst_port == 16'd0 &&
      out_traffic_class == ifke_pkg::CLS_OTHER)
    else $error("non-L4 key with ports or wrong class");

  a_udp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ip_protocol == ifke_pkg::PROTO_UDP |->
      out_traffic_class == ifke_pkg::CLS_UDP)
    else $error("UDP key with wrong class");

  a_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ip_protocol == ifke_pkg::PROTO_TCP |->
      out_traffic_class == ifke_pkg::CLS_TCP || out_traffic_class == ifke_pkg::CLS_HTTP ||
      out_traffic_class == ifke_pkg::CLS_HTTPS || out_traffic_class == ifke_pkg::CLS_DNS)
    else $error("TCP key with non-TCP class");

endmodule

bind ipv4_flow_key_extractor ifke_checker u_ifke_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_source_address (out_source_address),
  .out_dest_address   (out_dest_address),
  .out_src_port       (out_src_port),
  .out_dst_port       (out_dst_port),
  .out_ip_protocol    (out_ip_protocol),
  .out_traffic_class  (out_traffic_class)
);
